### rtl/wavs_pkg.sv
package wavs_pkg;

  // Default configuration of the filter
  localparam int WINDOW_DEF      = 16;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int COUNT_BITS_DEF  = $clog2(WINDOW_DEF + 1);

  // Status of the serial divider as seen by the controller
  typedef struct packed {
    logic busy;    // division in progress
    logic done;    // quotient register holds a finished result
  } wavs_div_stat_t;

endpackage

### rtl/wavs_ifs.sv
// Request channel: one sensor reading and its read status
interface wavs_in_if import wavs_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_value;
  logic                          sample_ok;

  modport source (output valid, sample_value, sample_ok, input ready);
  modport sink   (input valid, sample_value, sample_ok, output ready);
endinterface

// Result channel: window mean, its flag and the valid entry count
interface wavs_out_if import wavs_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] average;
  logic                          average_valid;
  logic [COUNT_BITS-1:0]         valid_count;

  modport source (output valid, average, average_valid, valid_count, input ready);
  modport sink   (input valid, average, average_valid, valid_count, output ready);
endinterface

### rtl/wavs_ram.sv
// Simple dual-port RAM, one write and one registered read per cycle
module wavs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/wavs_div.sv
// Bit-serial restoring divider: signed dividend by unsigned divisor,
// quotient truncated toward zero, one quotient bit per cycle
module wavs_div import wavs_pkg::*; #(
  parameter int DIVIDEND_W = 28,
  parameter int DIVISOR_W  = 5,
  parameter int QUOT_W     = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]         divisor,
  output logic signed [QUOT_W-1:0]     quotient,
  output wavs_div_stat_t               stat
);

  localparam int STEP_W = $clog2(DIVIDEND_W);

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_RUN  = 2'd1;
  localparam logic [1:0] D_FIN  = 2'd2;

  logic [1:0]              dstate_r, dstate_nxt;
  logic                    done_r, done_nxt;
  logic                    neg_r, neg_nxt;
  logic [DIVISOR_W-1:0]    dvs_r, dvs_nxt;
  logic [DIVISOR_W-1:0]    rem_r, rem_nxt;
  logic [DIVIDEND_W-1:0]   q_r, q_nxt;
  logic [STEP_W-1:0]       step_r, step_nxt;
  logic signed [QUOT_W-1:0] quot_r, quot_nxt;

  logic [DIVISOR_W:0]      shifted;
  logic [DIVISOR_W:0]      diff;
  logic                    ge;
  logic [QUOT_W-1:0]       mag;

  // one restoring step: bring down the next dividend bit and trial-subtract
  assign shifted = {rem_r, q_r[DIVIDEND_W-1]};
  assign ge      = shifted >= {1'b0, dvs_r};
  assign diff    = shifted - {1'b0, dvs_r};
  assign mag     = q_r[QUOT_W-1:0];

  always_comb begin
    dstate_nxt = dstate_r;
    done_nxt   = done_r;
    neg_nxt    = neg_r;
    dvs_nxt    = dvs_r;
    rem_nxt    = rem_r;
    q_nxt      = q_r;
    step_nxt   = step_r;
    quot_nxt   = quot_r;
    case (dstate_r)
      D_IDLE: begin
        if (start) begin
          // latch the magnitude; the dividend bits leave from the top of q_r
          neg_nxt    = dividend[DIVIDEND_W-1];
          q_nxt      = dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-dividend)
                                              : DIVIDEND_W'(dividend);
          dvs_nxt    = divisor;
          rem_nxt    = '0;
          step_nxt   = STEP_W'(DIVIDEND_W - 1);
          done_nxt   = 1'b0;
          dstate_nxt = D_RUN;
        end
      end
      D_RUN: begin
        rem_nxt  = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
        q_nxt    = {q_r[DIVIDEND_W-2:0], ge};
        step_nxt = step_r - STEP_W'(1);
        if (step_r == '0) begin
          dstate_nxt = D_FIN;
        end
      end
      D_FIN: begin
        // restore the sign of the quotient
        quot_nxt   = neg_r ? QUOT_W'(-mag) : QUOT_W'(mag);
        done_nxt   = 1'b1;
        dstate_nxt = D_IDLE;
      end
      default: begin
        dstate_nxt = D_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dstate_r <= D_IDLE;
      done_r   <= 1'b0;
    end else begin
      dstate_r <= dstate_nxt;
      done_r   <= done_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    neg_r  <= neg_nxt;
    dvs_r  <= dvs_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    step_r <= step_nxt;
    quot_r <= quot_nxt;
  end

  assign quotient  = quot_r;
  assign stat.busy = (dstate_r != D_IDLE);
  assign stat.done = done_r;

endmodule

### rtl/windowed_average_valid_samples_unit.sv
// Moving average over the last WINDOW sensor readings, counting only those
// whose read succeeded. Each request writes its reading into a ring, updates
// a running sum and valid count, and produces one result: the mean truncated
// toward zero, a flag that at least one valid entry is present, and the
// count. Before the ring first wraps only the entries written so far count.
// One request is processed at a time; after acceptance it steps through the
// remove, add, start and divide states, and the bit-serial divider, which
// produces one quotient bit per cycle over the width of the running sum,
// dominates the time until the next acceptance. The result
// sits in an output register, so a new request is accepted while the last
// result waits to be taken. The ring is a RAM that needs no clearing after
// reset: an entry is read back only once the ring has wrapped.
module windowed_average_valid_samples_unit import wavs_pkg::*; #(
  parameter int WINDOW      = WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  wavs_in_if.sink     in_req,
  wavs_out_if.source  out_res
);

  localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW);
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_REMOVE = 3'd1;
  localparam logic [2:0] S_ADD    = 3'd2;
  localparam logic [2:0] S_START  = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;

  logic [2:0]                    state_r, state_nxt;
  logic [PTR_W-1:0]              ptr_r, ptr_nxt;
  logic                          full_r, full_nxt;
  logic signed [SUM_W-1:0]       sum_r, sum_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic signed [SAMPLE_BITS-1:0] val_r, val_nxt;
  logic                          ok_r, ok_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] avg_r, avg_nxt;
  logic                          avg_valid_r, avg_valid_nxt;
  logic [CNT_W-1:0]              out_cnt_r, out_cnt_nxt;

  logic                          in_fire;
  logic                          load_out;
  logic                          ram_we;
  logic [SAMPLE_BITS:0]          ram_rdata;
  logic signed [SAMPLE_BITS-1:0] old_val;
  logic                          old_ok;
  logic                          div_start;
  logic signed [SAMPLE_BITS-1:0] div_quot;
  wavs_div_stat_t                div_stat;

  assign in_fire   = in_req.valid && in_req.ready;
  assign old_val   = ram_rdata[SAMPLE_BITS-1:0];
  assign old_ok    = ram_rdata[SAMPLE_BITS];
  assign ram_we    = (state_r == S_REMOVE);
  assign div_start = (state_r == S_START);
  assign load_out  = (state_r == S_DIV) && div_stat.done
                     && (!out_valid_r || out_res.ready);

  // ring of readings with their ok flags; read address follows the pointer
  wavs_ram #(
    .WIDTH (SAMPLE_BITS + 1),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ptr_r),
    .wdata ({ok_r, val_r}),
    .raddr (ptr_r),
    .rdata (ram_rdata)
  );

  // serial mean of the running sum
  wavs_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W),
    .QUOT_W     (SAMPLE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (cnt_r),
    .quotient (div_quot),
    .stat     (div_stat)
  );

  // sequencer and window bookkeeping
  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    full_nxt  = full_r;
    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;
    val_nxt   = val_r;
    ok_nxt    = ok_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          val_nxt   = in_req.sample_value;
          ok_nxt    = in_req.sample_ok;
          state_nxt = S_REMOVE;
        end
      end
      S_REMOVE: begin
        // drop the entry being overwritten once the ring has wrapped
        if (full_r && old_ok) begin
          sum_nxt = sum_r - SUM_W'(old_val);
          cnt_nxt = cnt_r - CNT_W'(1);
        end
        state_nxt = S_ADD;
      end
      S_ADD: begin
        if (ok_r) begin
          sum_nxt = sum_r + SUM_W'(val_r);
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        if (ptr_r == PTR_W'(WINDOW - 1)) begin
          ptr_nxt  = '0;
          full_nxt = 1'b1;
        end else begin
          ptr_nxt = ptr_r + PTR_W'(1);
        end
        state_nxt = S_START;
      end
      S_START: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    avg_nxt       = avg_r;
    avg_valid_nxt = avg_valid_r;
    out_cnt_nxt   = out_cnt_r;
    if (out_valid_r && out_res.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
      avg_valid_nxt = (cnt_r != '0);
      avg_nxt       = (cnt_r != '0) ? div_quot : '0;
      out_cnt_nxt   = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ptr_r       <= '0;
      full_r      <= 1'b0;
      sum_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      full_r      <= full_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r       <= val_nxt;
    ok_r        <= ok_nxt;
    avg_r       <= avg_nxt;
    avg_valid_r <= avg_valid_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

  assign in_req.ready          = (state_r == S_IDLE);
  assign out_res.valid         = out_valid_r;
  assign out_res.average       = avg_r;
  assign out_res.average_valid = avg_valid_r;
  assign out_res.valid_count   = out_cnt_r;

  // the valid count never exceeds the window
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(WINDOW))
    else $error("valid count exceeds window");

  // before the first wrap no more entries are valid than were written
  a_cnt_fill: assert property (@(posedge clk) disable iff (!rst_n)
    !full_r |-> (32'(cnt_r) <= 32'(ptr_r)))
    else $error("valid count ahead of write pointer");

  // the flag agrees with the count, and an empty window gives a zero mean
  a_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((avg_valid_r == (out_cnt_r != '0))
                     && (avg_valid_r || (avg_r == '0))))
    else $error("result flag inconsistent with count");

  // the divider only runs while the sequencer waits for it
  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> (state_r == S_DIV))
    else $error("divider busy outside divide phase");

  // no new request while one is in flight
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_req.ready)
    else $error("request accepted while busy");

endmodule
